[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker in ssb_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, quiet while rst_n is low
`define SSB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SSB_ASSERT_SAME(lbl, ante, cons, msg) \
    `SSB_ASSERT(lbl, (ante) |-> (cons), msg)

`define SSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    `SSB_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[hw/rtl/ssb_pkg.sv]
`default_nettype none

package ssb_pkg;

    localparam int DEF_MAX_ITEMS = 64;
    localparam int STORE_DEPTH   = 64;

    localparam int LAYER_W   = 32;
    localparam int TEX_W     = 32;
    localparam int KEY_W     = 64;
    localparam int SRC_W     = 6;
    localparam int BATCH_W   = 6;
    localparam int LEN_W     = 7;

    localparam logic [LAYER_W-1:0] LAYER_BIAS = 32'h8000_0000;

    typedef struct packed {
        logic [SRC_W-1:0] order;
        logic [KEY_W-1:0] key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_PLACE,
        ST_RUN_RD,
        ST_RUN_TEX,
        ST_RUN_SCAN,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/ssb_in_if.sv]
`default_nettype none

interface ssb_in_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [ssb_pkg::LAYER_W-1:0]   layer;
    logic        [ssb_pkg::TEX_W-1:0]     texture_id;
    logic                                 is_last;

    modport source (output valid, output layer, output texture_id, output is_last,
                    input ready);
    modport sink   (input valid, input layer, input texture_id, input is_last,
                    output ready);

endinterface

`default_nettype wire

[hw/rtl/ssb_out_if.sv]
`default_nettype none

interface ssb_out_if;

    logic                                 valid;
    logic                                 ready;
    logic        [ssb_pkg::SRC_W-1:0]     source_index;
    logic signed [ssb_pkg::LAYER_W-1:0]   out_layer;
    logic        [ssb_pkg::TEX_W-1:0]     out_texture;
    logic        [ssb_pkg::BATCH_W-1:0]   batch_number;
    logic                                 starts_batch;
    logic        [ssb_pkg::LEN_W-1:0]     batch_length;
    logic                                 overflowed;
    logic                                 last_of_run;

    modport source (output valid, output source_index, output out_layer,
                    output out_texture, output batch_number, output starts_batch,
                    output batch_length, output overflowed, output last_of_run,
                    input ready);
    modport sink   (input valid, input source_index, input out_layer,
                    input out_texture, input batch_number, input starts_batch,
                    input batch_length, input overflowed, input last_of_run,
                    output ready);

endinterface

`default_nettype wire

[hw/rtl/ssb_ram.sv]
`default_nettype none

module ssb_ram #(
    parameter int WIDTH = ssb_pkg::ENTRY_W,
    parameter int DEPTH = ssb_pkg::STORE_DEPTH
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hw/rtl/sprite_sort_and_batch.sv]
`default_nettype none

// Sorts a frame of draw items by {layer + 2^31, texture id}, stably, and emits them in
// order with run-of-texture batch information. Items are insertion-sorted into one
// single-port-read RAM as they arrive, one 64-bit key compare and one entry shift per
// cycle: every held entry whose key is greater than the new one is shifted up a slot,
// and the new item is then written into the gap. On the item marked last the sorted
// list is walked twice per batch through the same read port: once to measure the run
// of equal textures and once to emit it (one result per cycle while the output is
// taken). Input is not accepted during the sort or the emission; the last result may
// still wait in the output register while the next frame starts to load. Items beyond
// MAX_ITEMS are dropped and flag every result of that frame as overflowed.
module sprite_sort_and_batch #(
    parameter int MAX_ITEMS = ssb_pkg::DEF_MAX_ITEMS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ssb_in_if.sink      items,
    ssb_out_if.source   results
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] ONE = CW'(1);

    ssb_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                count_reg, count_next;
    logic                         overflow_reg, overflow_next;
    logic [CW-1:0]                pos_reg, pos_next;
    logic [CW-1:0]                i_reg, i_next;
    logic [CW-1:0]                j_reg, j_next;
    logic [CW-1:0]                len_reg, len_next;
    logic [ssb_pkg::BATCH_W-1:0]  batch_reg, batch_next;
    logic                         first_reg, first_next;
    logic                         last_reg, last_next;
    logic                         out_valid_reg, out_valid_next;

    logic [ssb_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [ssb_pkg::SRC_W-1:0]    arrival_reg, arrival_next;
    logic [ssb_pkg::TEX_W-1:0]    run_tex_reg, run_tex_next;
    ssb_pkg::entry_t              out_entry_reg, out_entry_next;
    logic [ssb_pkg::BATCH_W-1:0]  out_batch_reg, out_batch_next;
    logic                         out_starts_reg, out_starts_next;
    logic [ssb_pkg::LEN_W-1:0]    out_len_reg, out_len_next;
    logic                         out_ovf_reg, out_ovf_next;
    logic                         out_last_reg, out_last_next;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    ssb_pkg::entry_t              wr_data;
    logic [AW-1:0]                rd_addr;
    ssb_pkg::entry_t              rd_data;
    logic [ssb_pkg::ENTRY_W-1:0]  rd_bits;

    logic                         accept;
    logic                         load;
    logic [ssb_pkg::LAYER_W-1:0]  in_upper;

    ssb_ram #(
        .WIDTH (ssb_pkg::ENTRY_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_bits)
    );

    assign rd_data  = ssb_pkg::entry_t'(rd_bits);
    assign accept   = items.valid && items.ready;
    assign load     = !out_valid_reg || results.ready;
    assign in_upper = ssb_pkg::LAYER_W'(items.layer) ^ ssb_pkg::LAYER_BIAS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssb_pkg::ST_IDLE;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        len_reg        <= len_next;
        batch_reg      <= batch_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        key_reg        <= key_next;
        arrival_reg    <= arrival_next;
        run_tex_reg    <= run_tex_next;
        out_entry_reg  <= out_entry_next;
        out_batch_reg  <= out_batch_next;
        out_starts_reg <= out_starts_next;
        out_len_reg    <= out_len_next;
        out_ovf_reg    <= out_ovf_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        overflow_next   = overflow_reg;
        pos_next        = pos_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        len_next        = len_reg;
        batch_next      = batch_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        key_next        = key_reg;
        arrival_next    = arrival_reg;
        run_tex_next    = run_tex_reg;
        out_entry_next  = out_entry_reg;
        out_batch_next  = out_batch_reg;
        out_starts_next = out_starts_reg;
        out_len_next    = out_len_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !results.ready;

        items.ready = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = pos_reg[AW-1:0];
        wr_data     = rd_data;
        rd_addr     = i_reg[AW-1:0];

        case (state_reg)
            ssb_pkg::ST_IDLE:
            begin
                items.ready = 1'b1;
                rd_addr     = AW'(count_reg - ONE);
                if (accept)
                begin
                    key_next     = {in_upper, items.texture_id};
                    arrival_next = ssb_pkg::SRC_W'(count_reg);
                    last_next    = items.is_last;
                    pos_next     = count_reg;
                    i_next       = '0;
                    batch_next   = '0;
                    if (count_reg < CAP)
                    begin
                        state_next = (count_reg == '0) ? ssb_pkg::ST_PLACE : ssb_pkg::ST_CMP;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                        if (items.is_last)
                        begin
                            state_next = ssb_pkg::ST_RUN_RD;
                        end
                    end
                end
            end

            ssb_pkg::ST_CMP:
            begin
                // shift the greater entry up one slot and look one lower
                rd_addr = AW'(pos_reg - CW'(2));
                if (rd_data.key > key_reg)
                begin
                    wr_en    = 1'b1;
                    wr_data  = rd_data;
                    pos_next = pos_reg - ONE;
                    if (pos_reg == ONE)
                    begin
                        state_next = ssb_pkg::ST_PLACE;
                    end
                end
                else
                begin
                    state_next = ssb_pkg::ST_PLACE;
                end
            end

            ssb_pkg::ST_PLACE:
            begin
                wr_en         = 1'b1;
                wr_data.order = arrival_reg;
                wr_data.key   = key_reg;
                count_next    = count_reg + ONE;
                state_next    = last_reg ? ssb_pkg::ST_RUN_RD : ssb_pkg::ST_IDLE;
            end

            ssb_pkg::ST_RUN_RD:
            begin
                state_next = ssb_pkg::ST_RUN_TEX;
            end

            ssb_pkg::ST_RUN_TEX:
            begin
                run_tex_next = rd_data.key[ssb_pkg::TEX_W-1:0];
                j_next       = i_reg + ONE;
                first_next   = 1'b1;
                if (i_reg + ONE == count_reg)
                begin
                    len_next   = ONE;
                    state_next = ssb_pkg::ST_EMIT;
                end
                else
                begin
                    rd_addr    = AW'(i_reg + ONE);
                    state_next = ssb_pkg::ST_RUN_SCAN;
                end
            end

            ssb_pkg::ST_RUN_SCAN:
            begin
                if (rd_data.key[ssb_pkg::TEX_W-1:0] == run_tex_reg)
                begin
                    j_next = j_reg + ONE;
                    if (j_reg + ONE == count_reg)
                    begin
                        len_next   = count_reg - i_reg;
                        state_next = ssb_pkg::ST_EMIT;
                    end
                    else
                    begin
                        rd_addr = AW'(j_reg + ONE);
                    end
                end
                else
                begin
                    len_next   = j_reg - i_reg;
                    state_next = ssb_pkg::ST_EMIT;
                end
            end

            ssb_pkg::ST_EMIT:
            begin
                if (load)
                begin
                    rd_addr         = AW'(i_reg + ONE);
                    out_valid_next  = 1'b1;
                    out_entry_next  = rd_data;
                    out_batch_next  = batch_reg;
                    out_starts_next = first_reg;
                    out_len_next    = first_reg ? ssb_pkg::LEN_W'(len_reg) : '0;
                    out_ovf_next    = overflow_reg;
                    out_last_next   = (i_reg + ONE == count_reg);
                    first_next      = 1'b0;
                    i_next          = i_reg + ONE;
                    if (i_reg + ONE == count_reg)
                    begin
                        count_next    = '0;
                        overflow_next = 1'b0;
                        state_next    = ssb_pkg::ST_IDLE;
                    end
                    else if (i_reg + ONE == j_reg)
                    begin
                        batch_next = batch_reg + ssb_pkg::BATCH_W'(1);
                        state_next = ssb_pkg::ST_RUN_TEX;
                    end
                end
            end

            default:
            begin
                state_next = ssb_pkg::ST_IDLE;
            end
        endcase
    end

    assign results.valid        = out_valid_reg;
    assign results.source_index = out_entry_reg.order;
    assign results.out_layer    = signed'(out_entry_reg.key[ssb_pkg::KEY_W-1:ssb_pkg::TEX_W]
                                          ^ ssb_pkg::LAYER_BIAS);
    assign results.out_texture  = out_entry_reg.key[ssb_pkg::TEX_W-1:0];
    assign results.batch_number = out_batch_reg;
    assign results.starts_batch = out_starts_reg;
    assign results.batch_length = out_len_reg;
    assign results.overflowed   = out_ovf_reg;
    assign results.last_of_run  = out_last_reg;

endmodule

`default_nettype wire

[hw/rtl/ssb_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module ssb_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          in_is_last,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [ssb_pkg::SRC_W-1:0]     source_index,
    input wire logic [ssb_pkg::TEX_W-1:0]     out_texture,
    input wire logic [ssb_pkg::BATCH_W-1:0]   batch_number,
    input wire logic                          starts_batch,
    input wire logic [ssb_pkg::LEN_W-1:0]     batch_length,
    input wire logic                          last_of_run
);

    localparam logic [ssb_pkg::LEN_W-1:0] LEN_MAX = ssb_pkg::LEN_W'(ssb_pkg::STORE_DEPTH);

    logic                                                     out_stall;
    logic                                                     has_len;
    logic                                                     last_taken;
    logic [ssb_pkg::SRC_W+ssb_pkg::TEX_W+ssb_pkg::BATCH_W:0] out_view;

    assign out_stall  = out_valid && !out_ready;
    assign has_len    = (batch_length != '0);
    assign last_taken = in_valid && in_ready && in_is_last;
    assign out_view   = {source_index, out_texture, batch_number, last_of_run};

    `SSB_ASSERT_NEXT(a_out_hold, out_stall, out_valid, "result dropped while stalled")

    `SSB_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_view), "stalled result changed")

    `SSB_ASSERT_SAME(a_len_on_start, out_valid, starts_batch == has_len, "length and start disagree")

    `SSB_ASSERT_SAME(a_len_range, out_valid, batch_length <= LEN_MAX, "batch length beyond capacity")

    `SSB_ASSERT_NEXT(a_busy_after_last, last_taken, !in_ready, "input taken after the last one")

endmodule

bind sprite_sort_and_batch ssb_checker u_ssb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (items.valid),
    .in_ready     (items.ready),
    .in_is_last   (items.is_last),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .source_index (results.source_index),
    .out_texture  (results.out_texture),
    .batch_number (results.batch_number),
    .starts_batch (results.starts_batch),
    .batch_length (results.batch_length),
    .last_of_run  (results.last_of_run)
);

`default_nettype wire

[bench/ssb_result_checker.sv]
`timescale 1ns / 1ps

module ssb_result_checker #(
    parameter int MAX_ITEMS = ssb_pkg::DEF_MAX_ITEMS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ssb_in_if         items,
    ssb_out_if        results,
    output int        fail_count,
    output int        pending_count
);

    typedef struct packed {
        logic [ssb_pkg::SRC_W-1:0]          source_index;
        logic signed [ssb_pkg::LAYER_W-1:0] layer;
        logic [ssb_pkg::TEX_W-1:0]          texture;
        logic [ssb_pkg::BATCH_W-1:0]        batch_number;
        logic                               starts_batch;
        logic [ssb_pkg::LEN_W-1:0]          batch_length;
        logic                               overflowed;
        logic                               last_of_run;
    } draw_result_t;

    logic [ssb_pkg::KEY_W-1:0] sorted_keys  [ssb_pkg::STORE_DEPTH];
    logic [ssb_pkg::SRC_W-1:0] sorted_order [ssb_pkg::STORE_DEPTH];
    int                        held_count;
    logic                      frame_dropped;
    draw_result_t              expected_draws [$];
    int                        mismatches;

    function automatic void insert_sorted(logic [ssb_pkg::LAYER_W-1:0] layer,
                                          logic [ssb_pkg::TEX_W-1:0] tex);
        logic [ssb_pkg::KEY_W-1:0] key;
        int                        pos;
        if (held_count < MAX_ITEMS && held_count < ssb_pkg::STORE_DEPTH)
        begin
            key = {layer ^ ssb_pkg::LAYER_BIAS, tex};
            pos = held_count;
            while (pos > 0 && sorted_keys[pos-1] > key)
            begin
                sorted_keys[pos]  = sorted_keys[pos-1];
                sorted_order[pos] = sorted_order[pos-1];
                pos--;
            end
            sorted_keys[pos]  = key;
            sorted_order[pos] = held_count[ssb_pkg::SRC_W-1:0];
            held_count++;
        end
        else
        begin
            frame_dropped = 1'b1;
        end
    endfunction

    function automatic void queue_sorted_frame();
        draw_result_t              res;
        int                        i;
        int                        j;
        int                        batch;
        logic [ssb_pkg::TEX_W-1:0] tex;
        batch = 0;
        for (i = 0; i < held_count; i++)
        begin
            tex = sorted_keys[i][ssb_pkg::TEX_W-1:0];
            if (i == 0)
                res.starts_batch = 1'b1;
            else
                res.starts_batch = (sorted_keys[i-1][ssb_pkg::TEX_W-1:0] != tex);
            res.batch_length = '0;
            if (res.starts_batch)
            begin
                if (i != 0)
                    batch++;
                j = i;
                while (j < held_count && sorted_keys[j][ssb_pkg::TEX_W-1:0] == tex)
                    j++;
                res.batch_length = ssb_pkg::LEN_W'(j - i);
            end
            res.source_index = sorted_order[i];
            res.layer        = sorted_keys[i][ssb_pkg::KEY_W-1:ssb_pkg::TEX_W]
                               ^ ssb_pkg::LAYER_BIAS;
            res.texture      = tex;
            res.batch_number = ssb_pkg::BATCH_W'(batch);
            res.overflowed   = frame_dropped;
            res.last_of_run  = (i + 1 == held_count);
            expected_draws.insert(expected_draws.size(), res);
        end
        held_count    = 0;
        frame_dropped = 1'b0;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : watch
        draw_result_t want;
        if (!rst_n)
        begin
            held_count    = 0;
            frame_dropped = 1'b0;
            mismatches    = 0;
            expected_draws.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (items.valid && items.ready)
            begin
                insert_sorted(items.layer, items.texture_id);
                if (items.is_last)
                    queue_sorted_frame();
            end
            if (results.valid && results.ready)
            begin
                if (expected_draws.size() == 0)
                begin
                    $error("result transaction with nothing expected: source_index %0d",
                           results.source_index);
                    mismatches++;
                end
                else
                begin
                    want = expected_draws.pop_front();
                    check_field("source_index", want.source_index, results.source_index);
                    check_field("out_layer", $unsigned(want.layer), $unsigned(results.out_layer));
                    check_field("out_texture", want.texture, results.out_texture);
                    check_field("batch_number", want.batch_number, results.batch_number);
                    check_field("starts_batch", want.starts_batch, results.starts_batch);
                    check_field("batch_length", want.batch_length, results.batch_length);
                    check_field("overflowed", want.overflowed, results.overflowed);
                    check_field("last_of_run", want.last_of_run, results.last_of_run);
                end
            end
            fail_count    <= mismatches;
            pending_count <= expected_draws.size();
        end
    end

endmodule

[bench/tb_sprite_sort_and_batch.sv]
`timescale 1ns / 1ps

module tb_sprite_sort_and_batch;

    localparam int MAX_ITEMS    = ssb_pkg::DEF_MAX_ITEMS;
    localparam int RANDOM_ITEMS = 340;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 200;

    localparam logic signed [ssb_pkg::LAYER_W-1:0] LAYER_MIN = 32'sh8000_0000;
    localparam logic signed [ssb_pkg::LAYER_W-1:0] LAYER_MAX = 32'sh7FFF_FFFF;
    localparam logic [ssb_pkg::TEX_W-1:0]          TEX_MAX   = 32'hFFFF_FFFF;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending_count;
    int   idle_cycles = 0;
    bit   send_burst  = 1'b0;
    bit   take_burst  = 1'b0;

    ssb_in_if  items_ch ();
    ssb_out_if results_ch ();

    sprite_sort_and_batch #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items_ch),
        .results(results_ch)
    );

    ssb_result_checker #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .items        (items_ch),
        .results      (results_ch),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("sprite_sort_and_batch: mismatch");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic signed [ssb_pkg::LAYER_W-1:0] pick_layer();
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 4)) - 2;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return LAYER_MIN;
                    1: return LAYER_MAX;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [ssb_pkg::TEX_W-1:0] pick_texture();
        case ($urandom_range(0, 3))
            0, 1: return $urandom_range(0, 3);
            2: return $urandom_range(0, 1) ? TEX_MAX : '0;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(logic signed [ssb_pkg::LAYER_W-1:0] layer,
                             logic [ssb_pkg::TEX_W-1:0] tex, logic last);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            items_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_ch.valid      <= 1'b1;
        items_ch.layer      <= layer;
        items_ch.texture_id <= tex;
        items_ch.is_last    <= last;
        do @(posedge clk); while (!items_ch.ready);
    endtask

    task automatic send_frame(int size);
        for (int k = 0; k < size; k++)
            send_item(pick_layer(), pick_texture(), k == size - 1);
    endtask

    initial
    begin
        results_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin : take
            int gap;
            if ($urandom_range(0, 39) == 0)
                take_burst = !take_burst;
            gap = take_burst ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                results_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            results_ch.ready <= 1'b1;
            do @(posedge clk); while (!results_ch.valid);
        end
    end

    initial
    begin : stimulus
        int sent;
        int frame;
        int size;
        items_ch.valid      = 1'b0;
        items_ch.layer      = '0;
        items_ch.texture_id = '0;
        items_ch.is_last    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // single-item frame
        send_item(LAYER_MIN, TEX_MAX, 1'b1);

        // layer change alone keeps one batch
        send_item(LAYER_MAX, '0, 1'b0);
        send_item(LAYER_MIN, '0, 1'b0);
        send_item('0, '0, 1'b1);

        // equal keys hold arrival order
        send_item(5, 7, 1'b0);
        send_item(5, 7, 1'b0);
        send_item(5, 7, 1'b0);
        send_item(-1, 7, 1'b0);
        send_item(5, 7, 1'b1);

        // texture change opens a batch
        send_item(0, 3, 1'b0);
        send_item(0, 1, 1'b0);
        send_item(0, 2, 1'b0);
        send_item(1, 1, 1'b0);
        send_item(1, 1, 1'b0);
        send_item(-1, TEX_MAX, 1'b1);

        send_item(32'shAAAA_AAAA, 32'h5555_5555, 1'b0);
        send_item(32'sh5555_5555, 32'hAAAA_AAAA, 1'b0);
        send_item(-1, 32'h8000_0000, 1'b0);
        send_item(LAYER_MAX, TEX_MAX, 1'b1);

        // full capacity, then overflow with the last item dropped, then random frames
        sent  = 0;
        frame = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (frame == 0)
                size = MAX_ITEMS;
            else if (frame == 1)
                size = MAX_ITEMS + 3;
            else if ($urandom_range(0, 24) == 0)
                size = $urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 4);
            else
                size = $urandom_range(1, 10);
            send_frame(size);
            sent += size;
            frame++;
        end

        items_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("sprite_sort_and_batch: match");
        else
            $display("sprite_sort_and_batch: mismatch");
        $finish;
    end

endmodule
